// ----- rtl/fvn_pkg.sv -----
package fvn_pkg;

   localparam int COORD_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int LAT_W    = 8;    // lattice period 256, floor-mod is the low bits
   localparam int MUL_W    = 34;   // signed operands of the shared multiplier
   localparam int PROD_W   = 64;   // product bits kept
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FREQUENCY = 2'd2;

   localparam logic [31:0] HASH_SEED = 32'd1234;
   localparam logic [31:0] HASH_MUL  = 32'd15731;
   localparam logic [31:0] HASH_ADD1 = 32'd789221;
   localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
   localparam logic [17:0] SMOOTH_3  = 18'd196608;
   localparam logic [16:0] ONE_Q16   = 17'd65536;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_stat_type;

endpackage

// ----- rtl/fvn_mul.sv -----
module fvn_mul import fvn_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0]        prod
);

   logic signed [2*MUL_W-1:0] full;
   logic [PROD_W-1:0]         prod_ff;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full[PROD_W-1:0];
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/fvn_div.sv -----
module fvn_div import fvn_pkg::*; #(
   parameter int DIVS_W = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVS_W+FRAC_W-1:0]   dividend,
   input  logic [DIVS_W-1:0]          divisor,
   output div_stat_type               stat
);

   // quotient known to fit 16 bits: one quotient bit per cycle
   logic [DIVS_W:0]   rem_ff;
   logic [FRAC_W-1:0] lo_ff;
   logic [FRAC_W-1:0] q_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVS_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff[DIVS_W-1:0], lo_ff[FRAC_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd16;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend[DIVS_W+FRAC_W-1:FRAC_W]};
         lo_ff  <= dividend[FRAC_W-1:0];
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, divisor}) : trial;
         lo_ff  <= {lo_ff[FRAC_W-2:0], 1'b0};
         q_ff   <= {q_ff[FRAC_W-2:0], fits};
      end
   end

   assign stat.done     = done_ff;
   assign stat.quotient = q_ff;

endmodule

// ----- rtl/fractal_value_noise_2d.sv -----
// A request runs through PRE, SMO, HASH, BLD (per octave, n = clamped octave count, 1..MAX_OCTAVES)
// and DIV, then waits in OUT for the result to be taken.
// Throughput: one request at a time; the shared multiplier takes one product per cycle
// and the divider one quotient bit per cycle.
// Reset (synchronous, active high): idle, octave_count 4, persistence 0.5, frequency 1.0.
module fractal_value_noise_2d import fvn_pkg::*; #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,   // x_coord[31:0], z_coord[63:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // noise_value[15:0]
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_wdata
);

   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int AMP_W  = 16 + MAX_OCTAVES;
   localparam int ASUM_W = AMP_W + $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W  = ASUM_W + FRAC_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRE  = 3'd1;
   localparam logic [2:0] ST_SMO  = 3'd2;
   localparam logic [2:0] ST_HASH = 3'd3;
   localparam logic [2:0] ST_BLD  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [3:0]        phase_ff, phase_in;
   logic [1:0]        corner_ff, corner_in;
   logic [OCT_W-1:0]  oct_ff, oct_in;
   logic [OCT_W-1:0]  oct_n_ff;
   logic [3:0]        oct_cfg_ff;
   logic [16:0]       pers_ff;
   logic [23:0]       freq_ff;

   logic signed [COORD_W-1:0] x_ff, z_ff;
   logic [63:0]       bx_ff, bz_ff;
   logic [16:0]       u_ff, v_ff;
   logic [31:0]       h_ff;
   logic [15:0]       cv_ff [4];
   logic [32:0]       t_ff;
   logic [15:0]       k1_ff, k2_ff;
   logic [AMP_W-1:0]  amp_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [ASUM_W-1:0] asum_ff;
   logic [15:0]       res_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic              div_start;
   div_stat_type      div_stat;

   logic [OCT_W-1:0]  oct_clamp;
   logic [31:0]       cx, cz, key;
   logic [33:0]       blend_sum;
   logic [15:0]       blend_val;
   logic [31:0]       hmix;
   logic              last_oct;

   fvn_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   fvn_div #(.DIVS_W(ASUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (asum_ff),
      .stat     (div_stat)
   );

   // zero octaves run as one, anything above the maximum as the maximum
   always_comb begin
      if (oct_cfg_ff == 4'd0)
         oct_clamp = OCT_W'(1);
      else if (32'(oct_cfg_ff) > 32'(MAX_OCTAVES))
         oct_clamp = OCT_W'(MAX_OCTAVES);
      else
         oct_clamp = OCT_W'(oct_cfg_ff);
   end

   assign cx        = 32'(bx_ff[32 +: LAT_W]) + 32'(corner_ff[0]);
   assign cz        = 32'(bz_ff[32 +: LAT_W]) + 32'(corner_ff[1]);
   assign key       = (cx << 4) + cz;
   assign hmix      = (h_ff << 13) ^ h_ff;
   assign blend_sum = 34'(t_ff) + 34'(prod[32:0]);
   assign blend_val = blend_sum[31:16];
   assign last_oct  = (oct_ff + OCT_W'(1)) == oct_n_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_PRE: begin
            mul_a = MUL_W'(phase_ff[0] ? z_ff : x_ff);
            mul_b = MUL_W'({1'b0, freq_ff});
         end
         ST_SMO: begin
            unique case (phase_ff)
               4'd0: begin
                  mul_a = MUL_W'({1'b0, bx_ff[31:16]});
                  mul_b = MUL_W'({1'b0, bx_ff[31:16]});
               end
               4'd1: begin
                  mul_a = MUL_W'({1'b0, prod[31:0]});
                  mul_b = MUL_W'({1'b0, SMOOTH_3 - {1'b0, bx_ff[31:16], 1'b0}});
               end
               4'd2: begin
                  mul_a = MUL_W'({1'b0, bz_ff[31:16]});
                  mul_b = MUL_W'({1'b0, bz_ff[31:16]});
               end
               4'd3: begin
                  mul_a = MUL_W'({1'b0, prod[31:0]});
                  mul_b = MUL_W'({1'b0, SMOOTH_3 - {1'b0, bz_ff[31:16], 1'b0}});
               end
               default: ;
            endcase
         end
         ST_HASH: begin
            unique case (phase_ff)
               4'd0: begin
                  mul_a = MUL_W'({1'b0, key});
                  mul_b = MUL_W'({1'b0, HASH_SEED});
               end
               4'd1: begin
                  mul_a = MUL_W'({1'b0, prod[31:0]});
                  mul_b = MUL_W'({1'b0, prod[31:0]});
               end
               4'd2: begin
                  mul_a = MUL_W'({1'b0, prod[31:0]});
                  mul_b = MUL_W'({1'b0, HASH_MUL});
               end
               4'd3: begin
                  mul_a = MUL_W'({1'b0, h_ff});
                  mul_b = MUL_W'({1'b0, prod[31:0] + HASH_ADD1});
               end
               4'd4: begin
                  mul_a = MUL_W'({1'b0, hmix});
                  mul_b = MUL_W'({1'b0, prod[31:0] + HASH_ADD2});
               end
               default: ;
            endcase
         end
         ST_BLD: begin
            unique case (phase_ff)
               4'd0: begin
                  mul_a = MUL_W'({1'b0, cv_ff[0]});
                  mul_b = MUL_W'(ONE_Q16 - u_ff);
               end
               4'd1: begin
                  mul_a = MUL_W'({1'b0, cv_ff[1]});
                  mul_b = MUL_W'(u_ff);
               end
               4'd2: begin
                  mul_a = MUL_W'({1'b0, cv_ff[2]});
                  mul_b = MUL_W'(ONE_Q16 - u_ff);
               end
               4'd3: begin
                  mul_a = MUL_W'({1'b0, cv_ff[3]});
                  mul_b = MUL_W'(u_ff);
               end
               4'd4: begin
                  mul_a = MUL_W'({1'b0, k1_ff});
                  mul_b = MUL_W'(ONE_Q16 - v_ff);
               end
               4'd5: begin
                  mul_a = MUL_W'({1'b0, k2_ff});
                  mul_b = MUL_W'(v_ff);
               end
               4'd6: begin
                  mul_a = MUL_W'({1'b0, blend_val});
                  mul_b = MUL_W'({1'b0, amp_ff});
               end
               4'd7: begin
                  mul_a = MUL_W'({1'b0, amp_ff});
                  mul_b = MUL_W'({1'b0, pers_ff});
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff + 4'd1;
      corner_in = corner_ff;
      oct_in    = oct_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            phase_in = '0;
            oct_in   = '0;
            if (req_tvalid)
               state_in = ST_PRE;
         end
         ST_PRE: begin
            if (phase_ff == 4'd2) begin
               state_in = ST_SMO;
               phase_in = '0;
            end
         end
         ST_SMO: begin
            if (phase_ff == 4'd4) begin
               state_in  = ST_HASH;
               phase_in  = '0;
               corner_in = '0;
            end
         end
         ST_HASH: begin
            if (phase_ff == 4'd4) begin
               phase_in  = '0;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == 2'd3)
                  state_in = ST_BLD;
            end
         end
         ST_BLD: begin
            if (phase_ff == 4'd8) begin
               phase_in = '0;
               oct_in   = oct_ff + OCT_W'(1);
               if (last_oct) begin
                  state_in  = ST_DIV;
                  div_start = 1'b1;
               end else begin
                  state_in = ST_SMO;
               end
            end
         end
         ST_DIV: begin
            phase_in = '0;
            if (div_stat.done)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            phase_in = '0;
            if (rsp_tready)
               state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         corner_ff  <= '0;
         oct_ff     <= '0;
         oct_cfg_ff <= 4'd4;
         pers_ff    <= 17'd32768;
         freq_ff    <= 24'd65536;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         corner_ff <= corner_in;
         oct_ff    <= oct_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_OCTAVE_COUNT:   oct_cfg_ff <= csr_wdata[3:0];
               CSR_PERSISTENCE:    pers_ff    <= csr_wdata[16:0];
               CSR_BASE_FREQUENCY: freq_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath; each step takes the product issued in the cycle before
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff     <= req_tdata[31:0];
            z_ff     <= req_tdata[63:32];
            oct_n_ff <= oct_clamp;
            amp_ff   <= AMP_W'(ONE_Q16);
            sum_ff   <= '0;
            asum_ff  <= '0;
         end
         ST_PRE: begin
            if (phase_ff == 4'd1)
               bx_ff <= prod;
            if (phase_ff == 4'd2)
               bz_ff <= prod;
         end
         ST_SMO: begin
            if (phase_ff == 4'd2)
               u_ff <= prod[48:32];
            if (phase_ff == 4'd4)
               v_ff <= prod[48:32];
         end
         ST_HASH: begin
            if (phase_ff == 4'd0 && corner_ff != 2'd0)
               cv_ff[corner_ff - 2'd1] <= prod[30:15];
            if (phase_ff == 4'd1)
               h_ff <= prod[31:0];
         end
         ST_BLD: begin
            unique case (phase_ff)
               4'd0: cv_ff[3] <= prod[30:15];
               4'd1: t_ff     <= prod[32:0];
               4'd2: k1_ff    <= blend_val;
               4'd3: t_ff     <= prod[32:0];
               4'd4: k2_ff    <= blend_val;
               4'd5: t_ff     <= prod[32:0];
               4'd7: begin
                  sum_ff  <= sum_ff + SUM_W'(prod[15 + AMP_W:0]);
                  asum_ff <= asum_ff + ASUM_W'(amp_ff);
               end
               4'd8: begin
                  amp_ff <= prod[16 +: AMP_W];
                  bx_ff  <= {bx_ff[62:0], 1'b0};
                  bz_ff  <= {bz_ff[62:0], 1'b0};
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_stat.done)
               res_ff <= div_stat.quotient;
         end
         default: ;
      endcase
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tdata  = res_ff;

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides open together");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("response right after request");

   a_oct_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD) |-> (oct_ff < oct_n_ff))
      else $error("octave index past octave count");

   a_div_only_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");
`endif

endmodule

// ----- dv/fractal_value_noise_2d_test.sv -----
module fractal_value_noise_2d_test;
   import fvn_pkg::*;

   localparam int OCTAVE_LIMIT = 8;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;   // x_coord[31:0], z_coord[63:32]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;        // noise_value[15:0]
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // shadow copy of the configuration registers
   logic [3:0]  octave_reg;
   logic [16:0] persist_reg;
   logic [23:0] freq_reg;

   logic [15:0] noise_expected[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int samples_seen  = 0;
   int requests_sent = 0;
   int cycles        = 0;

   fractal_value_noise_2d #(.MAX_OCTAVES(OCTAVE_LIMIT)) u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] corner_hash(input logic [31:0] cx, input logic [31:0] cz);
      logic [31:0] h, m;
      h = (cx * 32'd16 + cz) * 32'd1234;
      m = h * (h * h * 32'd15731 + 32'd789221) + 32'd1376312589;
      h = ((h << 13) ^ h) * m;
      return {16'd0, h[30:15]};
   endfunction

   function automatic logic [63:0] smoothstep(input logic [15:0] f);
      logic [63:0] f2, t;
      f2 = 64'(f) * 64'(f);
      t  = 64'd196608 - 64'd2 * 64'(f);
      return (f2 * t) >> 32;
   endfunction

   function automatic logic [63:0] lerp16(input logic [63:0] lo, hi, s);
      return (lo * (64'd65536 - s) + hi * s) >> 16;
   endfunction

   function automatic logic [63:0] octave_sample(input logic [63:0] px, pz);
      logic [31:0] cx, cz;
      logic [63:0] u, v, k1, k2;
      cx = {24'd0, px[39:32]};
      cz = {24'd0, pz[39:32]};
      u  = smoothstep(px[31:16]);
      v  = smoothstep(pz[31:16]);
      k1 = lerp16(corner_hash(cx, cz), corner_hash(cx + 1, cz), u);
      k2 = lerp16(corner_hash(cx, cz + 1), corner_hash(cx + 1, cz + 1), u);
      return lerp16(k1, k2, v);
   endfunction

   function automatic logic [15:0] fbm_noise(input logic [31:0] x, z);
      logic [63:0] bx, bz, amp, sum, asum, q;
      int n;
      n = octave_reg;
      if (n < 1) n = 1;
      if (n > OCTAVE_LIMIT) n = OCTAVE_LIMIT;
      bx = {{32{x[31]}}, x} * 64'(freq_reg);
      bz = {{32{z[31]}}, z} * 64'(freq_reg);
      amp = 64'd65536; sum = 0; asum = 0;
      for (int i = 0; i < n; i++) begin
         sum  += octave_sample(bx << i, bz << i) * amp;
         asum += amp;
         amp   = (amp * 64'(persist_reg)) >> 16;
      end
      q = sum / asum;
      return q[15:0];
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("fractal_value_noise_2d_test NOT OK");
         $finish;
      end
   end

   // result side: random backpressure and checking
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            samples_seen <= samples_seen + 1;
            if (noise_expected.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected sample %h", rsp_tdata);
            end else begin
               logic [15:0] want;
               want = noise_expected.pop_front();
               if (want !== rsp_tdata) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("noise mismatch: expected %h got %h", want, rsp_tdata);
               end
            end
         end
      end
   end

   task automatic send_point(input logic [31:0] x, input logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, x};
      do @(posedge clock); while (!req_tready);
      noise_expected.push_back(fbm_noise(x, z));
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // one write to each register, plus one to the index past the list
   task automatic set_config(input logic [23:0] oct, pers, freq);
      logic [23:0] vals[4];
      logic [CSR_IDX_W-1:0] idx[4];
      vals = '{oct, pers, freq, 24'hA5A5A5};
      idx  = '{CSR_OCTAVE_COUNT, CSR_PERSISTENCE, CSR_BASE_FREQUENCY, CSR_UNUSED};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      octave_reg  = oct[3:0];
      persist_reg = pers[16:0];
      freq_reg    = freq;
      @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_point(32'h0001_8000, 32'h0002_4000);
      send_point(32'hFFFF_0000, 32'h7FFF_FFFF);
      drain();
   endtask

   task automatic test_directed();
      logic [31:0] pts[8];
      pts = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              32'h0000_FFFF, 32'h0001_0000, 32'h00FF_8000, 32'hFF00_0001};
      set_config(24'd0, 24'd65536, 24'hFFFFFF);      // zero octaves, max frequency
      for (int i = 0; i < 8; i++) send_point(pts[i], pts[7 - i]);
      drain();
      set_config(24'hFFFFFF, 24'hFFFFFF, 24'd0);     // masked values, zero frequency
      send_point(32'h1234_5678, 32'h8765_4321);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      set_config(24'd8, 24'd0, 24'h010000);          // max octaves, zero persistence
      for (int i = 0; i < 4; i++) send_point(pts[i], pts[i + 4]);
      drain();
      set_config(24'd9, 24'd65536, 24'h00C000);      // clamp above the octave limit
      for (int i = 0; i < 4; i++) send_point(pts[i + 4], pts[i]);
      drain();
   endtask

   task automatic test_random(input int sidle, input int ridle, input int items);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int blk = 0; blk < items / 50; blk++) begin
         logic [23:0] oct, pers, freq;
         // mostly short octave counts to keep the run short
         oct  = ($urandom_range(3) == 0) ? 24'($urandom_range(15)) : 24'($urandom_range(1, 3));
         pers = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(65536));
         case ($urandom_range(3))
            0: freq = 24'($urandom);
            1: freq = 24'($urandom_range(65536, 262144));
            2: freq = 24'h010000;
            default: freq = 24'($urandom_range(255));
         endcase
         set_config(oct, pers, freq);
         for (int i = 0; i < 50; i++) begin
            logic [31:0] x, z;
            if ($urandom_range(1)) begin
               x = $urandom; z = $urandom;
            end else begin
               x = 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
               z = 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
            end
            send_point(x, z);
            if (i == 25 && blk % 4 == 0) begin
               // let the block run dry before the next request
               req_tvalid <= 1'b0;
               while (noise_expected.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
   endtask

   initial begin
      octave_reg  = 4'd4;
      persist_reg = 17'd32768;
      freq_reg    = 24'h010000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_random(19, 61, 400);
      test_random(61, 19, 400);
      test_random(0, 0, 450);
      drain();
      $display("sent %0d points over random octave/persistence/frequency settings,", requests_sent);
      $display("checked %0d noise samples, %0d mismatches", samples_seen, mismatches);
      if (mismatches == 0 && noise_expected.size() == 0) begin
         $display("fractal_value_noise_2d_test OK");
      end else begin
         $display("fractal_value_noise_2d_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- fractal_value_noise_2d.f -----
rtl/fvn_pkg.sv
rtl/fvn_mul.sv
rtl/fvn_div.sv
rtl/fractal_value_noise_2d.sv
dv/fractal_value_noise_2d_test.sv
